[hw/rtl/line_segment_rect_clip_macros.svh]
// Assertion macros used by the checker file.
`ifndef LINE_SEGMENT_RECT_CLIP_MACROS_SVH
`define LINE_SEGMENT_RECT_CLIP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LSRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsrc check failed");
// Next-cycle implication checked outside reset.
`define LSRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsrc check failed");
`endif

[hw/rtl/lsrc_pkg.sv]
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared constants and register indexes of the segment clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int SIZE_BITS      = 15;
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } cfg_reg_t;
endpackage

[hw/rtl/lsrc_divider.sv]
// ----------------------------------------------------------------------------
// lsrc_divider
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module lsrc_divider #(
    parameter int NUM_BITS = 34,
    parameter int DEN_BITS = 17,
    parameter int TAG_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    input  logic [TAG_BITS-1:0] tag_in,
    output logic                out_valid,
    output logic [NUM_BITS-1:0] quot,
    output logic [TAG_BITS-1:0] tag_out
);
    logic [NUM_BITS-1:0] num_reg  [NUM_BITS+1];
    logic [NUM_BITS-1:0] quot_reg [NUM_BITS+1];
    logic [DEN_BITS:0]   rem_reg  [NUM_BITS+1];
    logic [DEN_BITS-1:0] den_reg  [NUM_BITS+1];
    logic [TAG_BITS-1:0] tag_reg  [NUM_BITS+1];
    logic [NUM_BITS:0]   vld_reg;

    always_comb
    begin
        num_reg[0]  = num;
        quot_reg[0] = '0;
        rem_reg[0]  = '0;
        den_reg[0]  = den;
        tag_reg[0]  = tag_in;
        vld_reg[0]  = in_valid;
    end

    // One shift-subtract step per stage.
    for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
        logic [DEN_BITS:0] shifted;
        logic [DEN_BITS:0] diff;
        logic              fits;
        always_comb
        begin
            shifted = {rem_reg[s][DEN_BITS-1:0], num_reg[s][NUM_BITS-1]};
            diff    = shifted - {1'b0, den_reg[s]};
            fits    = shifted >= {1'b0, den_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s+1]  <= {num_reg[s][NUM_BITS-2:0], 1'b0};
                rem_reg[s+1]  <= fits ? diff : shifted;
                quot_reg[s+1] <= {quot_reg[s][NUM_BITS-2:0], fits};
                den_reg[s+1]  <= den_reg[s];
                tag_reg[s+1]  <= tag_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NUM_BITS];
    assign quot      = quot_reg[NUM_BITS];
    assign tag_out   = tag_reg[NUM_BITS];
endmodule

[hw/rtl/line_segment_rect_clip.sv]
// ----------------------------------------------------------------------------
// line_segment_rect_clip
// Clips one line segment per beat to a configured rectangular window.
// ----------------------------------------------------------------------------
// Accepts one segment per clock while the output register is empty or taken,
// and returns one result per segment, in order. Segments pass through two
// chained pairs of bit-per-stage pipelined dividers, one pair for the column
// hits and one for the row hits, of NB stages each, where NB =
// 2*max(COORD_BITS,15)+2. Around them lie the ordering, classify, column
// product, row product and output registers.
// The whole pipeline advances when the output register is empty or taken,
// so a stall at the output holds every stage and loses nothing.
module line_segment_rect_clip #(
    parameter int COORD_BITS = lsrc_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // Config write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [(COORD_BITS > lsrc_pkg::SIZE_BITS ?
                   COORD_BITS : lsrc_pkg::SIZE_BITS)-1:0] cfg_data,
    // Slave side: start_x, start_y, stop_x, stop_y from bit 0 up.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // Master side tdata: clip_start_x, clip_start_y, clip_stop_x, clip_stop_y
    // from bit 0 up.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // Master side tuser: visible.
    output logic                        m_tuser
);
    import lsrc_pkg::*;

    localparam int EW  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int W   = EW + 2;               // edge and coordinate width
    localparam int D   = EW + 1;               // delta magnitude width
    localparam int NB  = 2 * D;                // product width
    localparam int OW  = ((4*COORD_BITS+7)/8)*8;
    // Tag: px,py,qx,qy,L,R,T,B (W each) plus dx,dy (W each) plus flags.
    localparam int TB  = 10 * W + 8;

    typedef logic signed [W-1:0] sc_t;

    logic en;
    logic out_vld_reg;
    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Window registers.
    logic signed [COORD_BITS-1:0] left_reg, top_reg;
    logic [SIZE_BITS-1:0]         width_reg, height_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LEFT:   left_reg   <= cfg_data[COORD_BITS-1:0];
                REG_TOP:    top_reg    <= cfg_data[COORD_BITS-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- Stage 1: order endpoints, edges ----------------
    sc_t ax, ay, bx, by;
    always_comb
    begin
        ax = sc_t'($signed(s_tdata[COORD_BITS-1:0]));
        ay = sc_t'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
        bx = sc_t'($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]));
        by = sc_t'($signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS]));
    end

    logic v1_reg;
    sc_t px1_reg, py1_reg, qx1_reg, qy1_reg, l1_reg, r1_reg, t1_reg, b1_reg;
    logic empty1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ax > bx)
            begin
                px1_reg <= bx; py1_reg <= by; qx1_reg <= ax; qy1_reg <= ay;
            end
            else
            begin
                px1_reg <= ax; py1_reg <= ay; qx1_reg <= bx; qy1_reg <= by;
            end
            l1_reg <= sc_t'(left_reg);
            t1_reg <= sc_t'(top_reg);
            r1_reg <= sc_t'(left_reg) + sc_t'({1'b0, width_reg});
            b1_reg <= sc_t'(top_reg) + sc_t'({1'b0, height_reg});
            empty1_reg <= (width_reg == '0) || (height_reg == '0);
        end
    end

    // ---------------- Stage 2: classify, form column offsets ----------------
    logic inb, ine;
    sc_t rm1, bm1, dx, dy;
    always_comb
    begin
        inb = l1_reg <= px1_reg && px1_reg < r1_reg && t1_reg <= py1_reg && py1_reg < b1_reg;
        ine = l1_reg <= qx1_reg && qx1_reg < r1_reg && t1_reg <= qy1_reg && qy1_reg < b1_reg;
        rm1 = r1_reg - sc_t'(1);
        bm1 = b1_reg - sc_t'(1);
        dx  = qx1_reg - px1_reg;
        dy  = qy1_reg - py1_reg;
    end

    logic v2_reg;
    sc_t px2_reg, py2_reg, qx2_reg, qy2_reg, l2_reg, r2_reg, t2_reg, b2_reg, dx2_reg, dy2_reg;
    logic [7:0] fl2_reg; // 0 empty,1 inb,2 ine,3 vert,4 horiz
    sc_t c0_reg, c1_reg; // column offsets X - px
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px2_reg <= px1_reg; py2_reg <= py1_reg; qx2_reg <= qx1_reg; qy2_reg <= qy1_reg;
            l2_reg <= l1_reg; r2_reg <= rm1; t2_reg <= t1_reg; b2_reg <= bm1;
            dx2_reg <= dx; dy2_reg <= dy;
            fl2_reg <= {3'b0, py1_reg == qy1_reg, px1_reg == qx1_reg, ine, inb, empty1_reg};
            c0_reg  <= l1_reg - px1_reg;
            c1_reg  <= rm1 - px1_reg;
        end
    end

    // ---------------- Stage 3: column products ----------------
    // Offsets fit in W bits; |dy|*|off| fits in NB bits.
    function automatic logic [D-1:0] magf(input sc_t v);
        sc_t n;
        begin
            n = v[W-1] ? -v : v;
            return n[D-1:0];
        end
    endfunction

    logic v3_reg;
    logic [NB-1:0] p0_reg, p1_reg;
    logic n0_reg, n1_reg;
    logic [TB-1:0] tag3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= NB'(magf(dy2_reg)) * NB'(magf(c0_reg));
            p1_reg <= NB'(magf(dy2_reg)) * NB'(magf(c1_reg));
            n0_reg <= dy2_reg[W-1] ^ c0_reg[W-1];
            n1_reg <= dy2_reg[W-1] ^ c1_reg[W-1];
            tag3_reg <= {fl2_reg, dy2_reg, dx2_reg, b2_reg, t2_reg, r2_reg, l2_reg,
                         qy2_reg, qx2_reg, py2_reg, px2_reg};
        end
    end

    // Two column divisions by dx share one pipeline tag; only the tag of the first
    // divider is used.
    localparam int TB2 = TB + 2 + NB;
    logic dva_v, dvb_v;
    logic [NB-1:0] qa, qb;
    logic [TB2-1:0] tga, tgb_unused;
    lsrc_divider #(.NUM_BITS(NB), .DEN_BITS(D), .TAG_BITS(TB2)) u_div_col0 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .num(p0_reg), .den(magf(tag3_reg[8*W +: W])),
        .tag_in({n1_reg, n0_reg, p1_reg, tag3_reg}),
        .out_valid(dva_v), .quot(qa), .tag_out(tga)
    );
    lsrc_divider #(.NUM_BITS(NB), .DEN_BITS(D), .TAG_BITS(TB2)) u_div_col1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg),
        .num(p1_reg), .den(magf(tag3_reg[8*W +: W])),
        .tag_in({n1_reg, n0_reg, p1_reg, tag3_reg}),
        .out_valid(dvb_v), .quot(qb), .tag_out(tgb_unused)
    );

    // ---------------- Stage 4: column hits, row products ----------------
    sc_t px4, py4, qx4, qy4, l4, r4, t4, b4, dx4, dy4;
    logic [7:0] fl4;
    logic n0_4, n1_4;
    logic signed [NB+1:0] ya, yb;
    logic [NB-1:0] unused_p;
    always_comb
    begin
        {n1_4, n0_4, unused_p, fl4, dy4, dx4, b4, t4, r4, l4, qy4, qx4, py4, px4} = tga;
        ya = (NB+2)'(py4) + (n0_4 ? -$signed({2'b0, qa}) : $signed({2'b0, qa}));
        yb = (NB+2)'(py4) + (n1_4 ? -$signed({2'b0, qb}) : $signed({2'b0, qb}));
    end

    logic ha, hb, oka, okb;
    sc_t ya_s, yb_s, rowa, rowb;
    always_comb
    begin
        ha  = (NB+2)'(t4) <= ya && ya <= (NB+2)'(b4);
        hb  = (NB+2)'(t4) <= yb && yb <= (NB+2)'(b4);
        rowa = dy4[W-1] ? b4 : t4;
        rowb = dy4[W-1] ? t4 : b4;
        // Row try allowed only from the proper side.
        oka = dy4[W-1] ? (ya > (NB+2)'(rowa)) : (ya < (NB+2)'(rowa));
        okb = dy4[W-1] ? (yb < (NB+2)'(rowb)) : (yb > (NB+2)'(rowb));
        ya_s = W'(ya);
        yb_s = W'(yb);
    end

    logic v5_reg;
    logic [NB-1:0] pr0_reg, pr1_reg;
    logic nr0_reg, nr1_reg;
    logic [TB-1:0] tag5_reg;
    logic [2*W+3:0] hit5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= dva_v && dvb_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr0_reg <= NB'(magf(rowa - py4)) * NB'(magf(dx4));
            pr1_reg <= NB'(magf(rowb - py4)) * NB'(magf(dx4));
            nr0_reg <= ((rowa - py4) < 0) ^ dy4[W-1];
            nr1_reg <= ((rowb - py4) < 0) ^ dy4[W-1];
            tag5_reg <= {fl4, dy4, dx4, b4, t4, r4, l4, qy4, qx4, py4, px4};
            hit5_reg <= {okb, oka, hb, ha, yb_s, ya_s};
        end
    end

    localparam int TB3 = TB + 2*W + 4;
    logic dr0_v, dr1_v;
    logic [NB-1:0] ra, rb;
    logic [TB3-1:0] tr, tr_unused;
    lsrc_divider #(.NUM_BITS(NB), .DEN_BITS(D), .TAG_BITS(TB3)) u_div_row0 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(pr0_reg), .den(magf(tag5_reg[9*W +: W])),
        .tag_in({hit5_reg, tag5_reg}),
        .out_valid(dr0_v), .quot(ra), .tag_out(tr)
    );
    lsrc_divider #(.NUM_BITS(NB), .DEN_BITS(D), .TAG_BITS(TB3)) u_div_row1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(pr1_reg), .den(magf(tag5_reg[9*W +: W])),
        .tag_in({hit5_reg, tag5_reg}),
        .out_valid(dr1_v), .quot(rb), .tag_out(tr_unused)
    );
    // nr flags ride a small shift line alongside the row dividers.
    logic [1:0] nr_line [NB+1];
    assign nr_line[0] = {nr1_reg, nr0_reg};
    for (genvar k = 0; k < NB; k++) begin : g_nr
        always_ff @(posedge clk)
        begin
            if (en)
                nr_line[k+1] <= nr_line[k];
        end
    end

    // ---------------- Stage 6: final selection ----------------
    sc_t px6, py6, qx6, qy6, l6, r6, t6, b6, dx6, dy6, ya6, yb6;
    logic [7:0] fl6;
    logic ha6, hb6, oka6, okb6;
    logic signed [NB+1:0] xa, xb;
    logic vis;
    sc_t o0, o1, o2, o3;
    logic okf, oks;

    function automatic sc_t clampf(input sc_t v, input sc_t lo, input sc_t hi);
        begin
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        end
    endfunction

    always_comb
    begin
        {okb6, oka6, hb6, ha6, yb6, ya6, fl6, dy6, dx6, b6, t6, r6, l6, qy6, qx6, py6, px6} = tr;
        xa = (NB+2)'(px6) + (nr_line[NB][0] ? -$signed({2'b0, ra}) : $signed({2'b0, ra}));
        xb = (NB+2)'(px6) + (nr_line[NB][1] ? -$signed({2'b0, rb}) : $signed({2'b0, rb}));
        vis = 1'b0;
        o0 = '0; o1 = '0; o2 = '0; o3 = '0;
        okf = 1'b1; oks = 1'b1;
        priority if (fl6[0])
        begin
            vis = 1'b0;
        end
        else if (fl6[1] && fl6[2])
        begin
            vis = 1'b1;
            o0 = px6; o1 = py6; o2 = qx6; o3 = qy6;
        end
        else if (fl6[3])
        begin
            if (l6 <= px6 && px6 <= r6 && !(py6 < t6 && qy6 < t6) && !(py6 > b6 && qy6 > b6))
            begin
                vis = 1'b1;
                o0 = px6; o1 = clampf(py6, t6, b6);
                o2 = qx6; o3 = clampf(qy6, t6, b6);
            end
        end
        else if (fl6[4])
        begin
            if (t6 <= py6 && py6 <= b6 && !(qx6 < l6) && !(px6 > r6))
            begin
                vis = 1'b1;
                o0 = clampf(px6, l6, r6); o1 = py6;
                o2 = clampf(qx6, l6, r6); o3 = qy6;
            end
        end
        else
        begin
            o0 = px6; o1 = py6; o2 = qx6; o3 = qy6;
            if (!fl6[1])
            begin
                if (ha6)
                begin
                    o0 = l6; o1 = ya6;
                end
                else if (oka6 && (NB+2)'(l6) <= xa && xa <= (NB+2)'(r6))
                begin
                    o0 = W'(xa); o1 = dy6[W-1] ? b6 : t6;
                end
                else
                    okf = 1'b0;
            end
            if (!fl6[2])
            begin
                if (hb6)
                begin
                    o2 = r6; o3 = yb6;
                end
                else if (okb6 && (NB+2)'(l6) <= xb && xb <= (NB+2)'(r6))
                begin
                    o2 = W'(xb); o3 = dy6[W-1] ? t6 : b6;
                end
                else
                    oks = 1'b0;
            end
            vis = okf && oks;
            if (!vis)
            begin
                o0 = '0; o1 = '0; o2 = '0; o3 = '0;
            end
        end
    end

    // Output register.
    logic [OW-1:0] out_reg;
    logic          vis_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dr0_v && dr1_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= OW'({o3[COORD_BITS-1:0], o2[COORD_BITS-1:0],
                            o1[COORD_BITS-1:0], o0[COORD_BITS-1:0]});
            vis_reg <= vis;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = vis_reg;
endmodule

[hw/rtl/lsrc_checker.sv]
// ----------------------------------------------------------------------------
// lsrc_checker
// Port-level checks of the segment clipper, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_segment_rect_clip_macros.svh"
module lsrc_checker #(
    parameter int OW = 64
) (
    input logic          clk,
    input logic          rst_n,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic          s_tready,
    input logic [OW-1:0] m_tdata,
    input logic          m_tuser
);
    `LSRC_ASSERT_NXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `LSRC_ASSERT_NXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `LSRC_ASSERT_IMP(a_ready_free, clk, rst_n, !m_tvalid, s_tready)
    `LSRC_ASSERT_IMP(a_reject_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0)
endmodule

bind line_segment_rect_clip lsrc_checker #(.OW(((4*COORD_BITS+7)/8)*8)) u_lsrc_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .s_tready(s_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[verif/tb_line_segment_rect_clip.sv]
// ----------------------------------------------------------------------------
// tb_line_segment_rect_clip
// Self-checking testbench of the segment clipper.
// ----------------------------------------------------------------------------
// Segments are sent over the input stream with random gaps. Each accepted
// beat is run through a behavioral clipper inside this bench, and the result
// is queued. Every output beat is checked field by field against the oldest
// queued result. The window registers are rewritten between phases, covering
// empty, tiny, ordinary and extreme windows.
`timescale 1ns / 100ps

module tb_line_segment_rect_clip;
    import lsrc_pkg::*;

    localparam int CB = 16;
    localparam int SW = ((4*CB+7)/8)*8;
    localparam int MW = ((4*CB+7)/8)*8;
    localparam int LATENCY = 2*(2*CB+2)+6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint QLIM = 64'sd1 <<< 62;

    typedef struct packed {
        logic          visible;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } clip_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CB-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [SW-1:0] s_tdata;   // start_x, start_y, stop_x, stop_y
    logic m_tvalid;
    logic m_tready;
    logic [MW-1:0] m_tdata;   // clip_start_x, clip_start_y, clip_stop_x, clip_stop_y
    logic m_tuser;            // visible

    // Window held by the bench.
    longint win_left, win_top, win_width, win_height;

    clip_result_t clipped_q[$];
    int fail_count;
    int idle_cycles;
    int hold_cycles;

    line_segment_rect_clip #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Truncating a*b/c with saturation; operands are small enough for 64 bits.
    function automatic longint scale_trunc(longint a, longint b, longint c);
        longint q;
        q = (a * b) / c;
        if (q > QLIM)
            q = QLIM;
        if (q < -QLIM)
            q = -QLIM;
        return q;
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Moves an outside end onto column cx, else onto row ry.
    function automatic bit slide_end(longint bx, longint by, longint dx, longint dy,
                                     longint cx, longint ry, bit above,
                                     longint l, longint r, longint t, longint b,
                                     output longint ox, output longint oy);
        longint y;
        longint x;
        ox = 0;
        oy = 0;
        y = by + scale_trunc(dy, cx - bx, dx);
        if (t <= y && y < b)
        begin
            ox = cx;
            oy = y;
            return 1'b1;
        end
        if (above ? !(y < ry) : !(y > ry))
            return 1'b0;
        x = bx + scale_trunc(ry - by, dx, dy);
        if (x < l || x >= r)
            return 1'b0;
        ox = x;
        oy = ry;
        return 1'b1;
    endfunction

    function automatic clip_result_t clip_segment(logic [SW-1:0] seg);
        longint bx, by, ex, ey, l, t, r, b, tmp, dx, dy;
        longint o0, o1, o2, o3;
        bit vis, inb, ine, ok;
        clip_result_t res;
        bx = longint'($signed(seg[0*CB +: CB]));
        by = longint'($signed(seg[1*CB +: CB]));
        ex = longint'($signed(seg[2*CB +: CB]));
        ey = longint'($signed(seg[3*CB +: CB]));
        l = win_left;
        t = win_top;
        r = l + win_width;
        b = t + win_height;
        o0 = 0; o1 = 0; o2 = 0; o3 = 0;
        vis = 1'b0;
        if (bx > ex)
        begin
            tmp = bx; bx = ex; ex = tmp;
            tmp = by; by = ey; ey = tmp;
        end
        inb = l <= bx && bx < r && t <= by && by < b;
        ine = l <= ex && ex < r && t <= ey && ey < b;
        if (win_width == 0 || win_height == 0)
            vis = 1'b0;
        else if (inb && ine)
        begin
            vis = 1'b1;
            o0 = bx; o1 = by; o2 = ex; o3 = ey;
        end
        else if (bx == ex)
        begin
            if (l <= bx && bx < r && !(by < t && ey < t) && !(by >= b && ey >= b))
            begin
                vis = 1'b1;
                o0 = bx; o1 = clamp_to(by, t, b - 1);
                o2 = ex; o3 = clamp_to(ey, t, b - 1);
            end
        end
        else if (by == ey)
        begin
            if (t <= by && by < b && !(ex < l) && !(bx >= r))
            begin
                vis = 1'b1;
                o0 = clamp_to(bx, l, r - 1); o1 = by;
                o2 = clamp_to(ex, l, r - 1); o3 = ey;
            end
        end
        else
        begin
            dx = ex - bx;
            dy = ey - by;
            ok = 1'b1;
            o0 = bx; o1 = by; o2 = ex; o3 = ey;
            if (!inb)
                ok = slide_end(bx, by, dx, dy, l, dy > 0 ? t : b - 1, dy > 0,
                               l, r, t, b, o0, o1);
            if (ok && !ine)
                ok = slide_end(bx, by, dx, dy, r - 1, dy > 0 ? b - 1 : t, dy < 0,
                               l, r, t, b, o2, o3);
            vis = ok;
        end
        res.visible = vis;
        res.sx = vis ? o0[CB-1:0] : '0;
        res.sy = vis ? o1[CB-1:0] : '0;
        res.ex = vis ? o2[CB-1:0] : '0;
        res.ey = vis ? o3[CB-1:0] : '0;
        return res;
    endfunction

    // Writes one window register; only called while the block is idle.
    // The caller drops cfg_valid after its last write.
    task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LEFT:   win_left   = longint'($signed(value));
            REG_TOP:    win_top    = longint'($signed(value));
            REG_WIDTH:  win_width  = longint'(value[SIZE_BITS-1:0]);
            REG_HEIGHT: win_height = longint'(value[SIZE_BITS-1:0]);
            default: ;
        endcase
    endtask

    // Stops offering, waits for all results, then lets the pipeline drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (clipped_q.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_window(int l, int t, int w, int h);
        drain();
        write_reg(REG_LEFT, CB'(l));
        write_reg(REG_TOP, CB'(t));
        write_reg(REG_WIDTH, CB'(w));
        write_reg(REG_HEIGHT, CB'(h));
        cfg_valid <= 1'b0;
    endtask

    // Sends one segment beat after a random gap. With no gap the valid stays
    // high from the previous beat.
    task automatic send_segment(int sx, int sy, int ex, int ey, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {CB'(ey), CB'(ex), CB'(sy), CB'(sx)};
        do
            @(posedge clk);
        while (!s_tready);
        clipped_q.push_back(clip_segment({CB'(ey), CB'(ex), CB'(sy), CB'(sx)}));
    endtask

    // Coordinate near the window, or anywhere in range.
    function automatic int pick_coord(longint lo, longint span);
        int v;
        if ($urandom_range(0, 4) == 0)
            v = $signed(CB'($urandom));
        else
            v = int'(lo) + $urandom_range(0, int'(span) + 40) - 20;
        return v;
    endfunction

    task automatic test_reset_window();
        send_segment(0, 0, 0, 0);
        send_segment(5, 5, 10, 20);
    endtask

    task automatic test_directed();
        set_window(10, 20, 100, 50);
        send_segment(20, 30, 60, 40);       // both inside
        send_segment(60, 40, 20, 30);       // swapped order
        send_segment(50, 0, 50, 200);       // vertical crossing
        send_segment(50, 0, 50, 10);        // vertical above
        send_segment(200, 30, 200, 40);     // vertical outside column
        send_segment(0, 30, 300, 30);       // horizontal crossing
        send_segment(0, 30, 5, 30);         // horizontal left of window
        send_segment(30, 30, 30, 30);       // single point inside
        send_segment(5, 5, 5, 5);           // single point outside
        send_segment(0, 0, 200, 100);       // sloped, both outside
        send_segment(0, 100, 200, 0);       // sloped, falling
        send_segment(0, 21, 200, 19);       // sloped, grazes top
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-1, -1, 32767, -32768);
        set_window(-32768, -32768, 32767, 32767);
        send_segment(-32768, -32768, -2, -2);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(-1, 0, -1, 32767);
        set_window(32767, 32767, 32767, 32767);  // edges past the range
        send_segment(32767, 32767, 32767, 32767);
        send_segment(32767, 0, 32767, 32767);
        send_segment(0, 32767, 32767, 32767);
        send_segment(0, 0, 32767, 32767);
        set_window(0, 0, 0, 10);            // empty window
        send_segment(0, 0, 0, 0);
    endtask

    task automatic test_random(int count, int l, int t, int w, int h);
        int sx, sy, ex, ey, kind;
        set_window(l, t, w, h);
        for (int i = 0; i < count; i++)
        begin
            sx = pick_coord(l, w);
            sy = pick_coord(t, h);
            ex = pick_coord(l, w);
            ey = pick_coord(t, h);
            kind = $urandom_range(0, 5);
            if (kind == 0)
                ex = sx;
            else if (kind == 1)
                ey = sy;
            send_segment(sx, sy, ex, ey);
        end
    endtask

    // Receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        drain();
        hold_cycles = 300;
        for (int i = 0; i < 120; i++)
            send_segment($signed(CB'($urandom)), $signed(CB'($urandom)),
                         $signed(CB'($urandom)), $signed(CB'($urandom)), 1'b1);
    endtask

    // Output side: random wait per beat, forced hold-off, and checking.
    initial
    begin
        clip_result_t got;
        clip_result_t want;
        int rx_wait;
        m_tready = 1'b0;
        hold_cycles = 0;
        rx_wait = $urandom_range(0, 9);
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.visible = m_tuser;
                got.sx = m_tdata[0*CB +: CB];
                got.sy = m_tdata[1*CB +: CB];
                got.ex = m_tdata[2*CB +: CB];
                got.ey = m_tdata[3*CB +: CB];
                if (clipped_q.size() == 0)
                begin
                    $error("result beat with no segment pending");
                    fail_count++;
                end
                else
                begin
                    want = clipped_q.pop_front();
                    if (got.visible !== want.visible)
                    begin
                        $error("visible: expected %0d, got %0d", want.visible, got.visible);
                        fail_count++;
                    end
                    if (got.sx !== want.sx)
                    begin
                        $error("clip_start_x: expected %0d, got %0d",
                               $signed(want.sx), $signed(got.sx));
                        fail_count++;
                    end
                    if (got.sy !== want.sy)
                    begin
                        $error("clip_start_y: expected %0d, got %0d",
                               $signed(want.sy), $signed(got.sy));
                        fail_count++;
                    end
                    if (got.ex !== want.ex)
                    begin
                        $error("clip_stop_x: expected %0d, got %0d",
                               $signed(want.ex), $signed(got.ex));
                        fail_count++;
                    end
                    if (got.ey !== want.ey)
                    begin
                        $error("clip_stop_y: expected %0d, got %0d",
                               $signed(want.ey), $signed(got.ey));
                        fail_count++;
                    end
                end
                rx_wait = $urandom_range(0, 9);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        fail_count = 0;
        idle_cycles = 0;
        win_left = 0;
        win_top = 0;
        win_width = 0;
        win_height = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_directed();
        test_random(120, 100, -50, 200, 120);
        test_random(60, -30, -30, 1, 1);
        test_random(80, -32768, 32000, 32767, 767);
        test_random(70, 32000, -32768, 767, 32767);
        test_backpressure();
        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
